// ===== rtl/mva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_pkg: shared types and constants of the voice allocator
// Widths, message kinds, mode codes and the cell command record.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int unsigned Voices    = 6;
  localparam int unsigned ListDepth = 24;
  localparam int unsigned VoiceW    = $clog2(Voices);
  localparam int unsigned IdxW      = 3;
  localparam int unsigned LenW      = $clog2(ListDepth + 1);

  localparam logic [3:0] KindNoteOff  = 4'h8;
  localparam logic [3:0] KindNoteOn   = 4'h9;
  localparam logic [3:0] KindPolyPres = 4'hA;
  localparam logic [3:0] KindCtrl     = 4'hB;
  localparam logic [6:0] CtrlSustain  = 7'h40;
  localparam logic [6:0] NoteReset    = 7'd60;

  localparam logic [1:0] ModeRotate   = 2'd0;
  localparam logic [1:0] ModeReset    = 2'd1;
  localparam logic [1:0] ModeReassign = 2'd2;

  // configuration register indexes
  localparam logic [0:0] RegChannelFilter = 1'b0;
  localparam logic [0:0] RegVoiceMode     = 1'b1;

  // list cell operation, same for every cell of the row
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_SET_FRONT,
    OP_WRITE_AT,
    OP_COMPACT,
    OP_SORT_ODD,
    OP_SORT_EVEN
  } list_op_e;

  typedef struct packed {
    list_op_e          op;
    logic [VoiceW-1:0] value;
    logic [LenW-1:0]   pos;
  } list_cmd_t;

endpackage

// ===== rtl/mva_list_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_list_cell: one entry of the free-voice list
// Holds one voice number and exchanges it with its neighbors on command.
// ----------------------------------------------------------------------------
module mva_list_cell
  import mva_pkg::*;
(
  input  logic              clk_i,
  input  list_cmd_t         cmd_i,
  input  logic [LenW-1:0]   my_pos_i,
  input  logic [VoiceW-1:0] prev_i,
  input  logic [VoiceW-1:0] next_i,
  input  logic [VoiceW-1:0] comp_i,
  input  logic              comp_valid_i,
  output logic [VoiceW-1:0] value_o
);

  logic [VoiceW-1:0] val_q, val_d;

  // next value per command; in a compare-exchange the lower cell of a pair keeps the minimum
  always_comb begin
    val_d = val_q;
    case (cmd_i.op)
      OP_SHIFT_UP:   val_d = prev_i;
      OP_SHIFT_DOWN: val_d = next_i;
      OP_SET_FRONT:  if (my_pos_i == '0) val_d = cmd_i.value; else val_d = prev_i;
      OP_WRITE_AT:   if (my_pos_i == cmd_i.pos) val_d = cmd_i.value;
      OP_COMPACT:    if (comp_valid_i) val_d = comp_i;
      OP_SORT_ODD, OP_SORT_EVEN: begin
        if (my_pos_i[0] == (cmd_i.op == OP_SORT_ODD)) begin
          if (my_pos_i + LenW'(1) < cmd_i.pos && next_i < val_q) val_d = next_i;
        end else if (my_pos_i < cmd_i.pos && prev_i > val_q) begin
          val_d = prev_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

// ===== rtl/midi_voice_allocator_unit.sv =====
`timescale 1ns / 1ps
// Polyphonic voice allocator: each accepted transaction (a MIDI message or a
// reset event) updates six voices and then streams six voice-state
// transactions, last one marked by tlast. The free-voice list is a row of
// cells that shift, insert, compact and odd-even sort together, one step a
// cycle; the time an item takes, beyond output stalls, is dominated by the sort
// pass (list length plus one steps) and one compaction step per removed list
// entry. The next item is accepted once all six states of the previous one are
// taken.
// ----------------------------------------------------------------------------
// midi_voice_allocator_unit: top level
// Message decode, voice store, list sequencer and output stream.
// ----------------------------------------------------------------------------
module midi_voice_allocator_unit
  import mva_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // status_byte[7:0], data_one[14:8], data_two[21:15]
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // voice_index[2:0], voice_gate[3], voice_note[10:4], voice_velocity[17:11],
  // voice_pressure[24:18]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast   // last_voice
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_DEC = 5'd1,  S_OFF = 5'd2,
    S_OFF_RM = 5'd3, S_OFF_PF = 5'd4, S_ON_FILL = 5'd5, S_SORT = 5'd6,
    S_MODE = 5'd7, S_POP = 5'd8, S_RE = 5'd9, S_RE_RM = 5'd10, S_RE_PF = 5'd11,
    S_FIN = 5'd12, S_OUT = 5'd13, S_PB = 5'd14, S_MODE2 = 5'd15;

  // where the push-back run continues
  localparam logic [2:0] RetFin = 3'd0, RetFill = 3'd1, RetPop = 3'd2;

  logic [4:0] st_q;
  logic signed [4:0] cf_q;
  logic [1:0] mode_q;
  logic [6:0] note_q [Voices], vel_q [Voices], pres_q [Voices];
  logic [Voices-1:0] gate_q;
  logic [LenW-1:0] len_q;
  logic sus_q;
  logic [7:0] stat_q;
  logic [6:0] d1_q, d2_q;
  logic [VoiceW-1:0] vi_q, next_q;
  logic [LenW-1:0] cnt_q;
  logic [LenW:0] rmp_q;
  logic [VoiceW-1:0] pb_q;
  logic [2:0] pbret_q;
  logic [VoiceW:0] oi_q;
  logic ov_q;
  logic found;
  logic [LenW:0] fpos;

  list_cmd_t cmd;
  logic [VoiceW-1:0] cell_v [ListDepth];
  logic [VoiceW-1:0] cprev [ListDepth], cnext [ListDepth], ccomp [ListDepth];
  logic ccv [ListDepth];

  // row of list cells; compaction drops the first match at fpos
  for (genvar g = 0; g < ListDepth; g++) begin : g_cell
    assign cprev[g] = (g == 0) ? cell_v[0] : cell_v[(g == 0) ? 0 : g-1];
    assign cnext[g] = (g == ListDepth-1) ? cell_v[g] : cell_v[(g == ListDepth-1) ? g : g+1];
    assign ccomp[g] = cnext[g];
    assign ccv[g]   = (LenW+1)'(g) >= fpos;
    mva_list_cell u_cell (
      .clk_i, .cmd_i(cmd), .my_pos_i(LenW'(g)),
      .prev_i(cprev[g]), .next_i(cnext[g]), .comp_i(ccomp[g]),
      .comp_valid_i(ccv[g]), .value_o(cell_v[g])
    );
  end

  logic [3:0] kind;
  logic chan_ok, any_on;
  logic [VoiceW-1:0] head;
  assign kind    = stat_q[7:4];
  assign chan_ok = cf_q[4] || (cf_q[3:0] == stat_q[3:0]);
  assign any_on  = |gate_q;
  assign head    = cell_v[0];

  // search for the first cell at or after rmp holding vi
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    for (int k = ListDepth-1; k >= 0; k--) begin
      if ((LenW+1)'(k) >= rmp_q && (LenW+1)'(k) < {1'b0, len_q} && cell_v[k] == vi_q) begin
        found = 1'b1;
        fpos  = (LenW+1)'(k);
      end
    end
  end

  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cf_q <= -5'sd1; mode_q <= ModeReassign;
      gate_q <= '0; len_q <= '0; sus_q <= 1'b0; ov_q <= 1'b0; oi_q <= '0;
      cnt_q <= '0; rmp_q <= '0; vi_q <= '0; next_q <= '0; pb_q <= '0; pbret_q <= RetFin;
      stat_q <= '0; d1_q <= '0; d2_q <= '0;
      for (int i = 0; i < Voices; i++) begin
        note_q[i] <= NoteReset; vel_q[i] <= '0; pres_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegChannelFilter) cf_q <= $signed(cfg_data_i);
        else mode_q <= cfg_data_i[1:0];
      end
      case (st_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          stat_q <= s_axis_tdata[7:0];
          d1_q <= s_axis_tdata[14:8];
          d2_q <= s_axis_tdata[21:15];
          if (s_axis_tuser) begin
            gate_q <= '0; len_q <= '0; sus_q <= 1'b0;
            for (int i = 0; i < Voices; i++) begin vel_q[i] <= '0; pres_q[i] <= '0; end
            st_q <= S_FIN;
          end else st_q <= S_DEC;
        end
        S_DEC: begin
          if (!chan_ok) begin
            st_q <= S_FIN;
          end else if (kind == KindPolyPres) begin
            for (int i = 0; i < Voices; i++) if (note_q[i] == d1_q) pres_q[i] <= d2_q;
            st_q <= S_FIN;
          end else if (kind == KindCtrl) begin
            if (d1_q == CtrlSustain) begin
              sus_q <= d2_q[6];
              if (!d2_q[6]) begin
                gate_q <= '0; len_q <= '0; pb_q <= '0; pbret_q <= RetFin; st_q <= S_PB;
              end else st_q <= S_FIN;
            end else st_q <= S_FIN;
          end else if (kind == KindNoteOff || (kind == KindNoteOn && d2_q == '0)) begin
            if (!sus_q) begin vi_q <= '0; st_q <= S_OFF; end
            else st_q <= S_FIN;
          end else if (kind == KindNoteOn) begin
            if (len_q == '0) begin pb_q <= '0; pbret_q <= RetFill; st_q <= S_PB; end
            else st_q <= S_ON_FILL;
          end else begin
            st_q <= S_FIN;
          end
        end
        // push voices 0..n-1 to the back, then return
        S_PB: begin
          if (len_q < LenW'(ListDepth)) len_q <= len_q + LenW'(1);
          if (32'(pb_q) == Voices-1) begin
            case (pbret_q)
              RetFin:  st_q <= S_FIN;
              RetFill: st_q <= S_ON_FILL;
              default: st_q <= S_POP;
            endcase
          end
          pb_q <= pb_q + VoiceW'(1);
        end
        S_ON_FILL: begin cnt_q <= '0; st_q <= any_on ? S_MODE : S_SORT; end
        S_SORT: begin
          cnt_q <= cnt_q + LenW'(1);
          if (cnt_q >= len_q) st_q <= S_MODE;
        end
        S_MODE: begin
          if (mode_q == ModeReset && 32'(len_q) == Voices) begin
            gate_q <= '0; pb_q <= '0; pbret_q <= RetPop; st_q <= S_PB;
          end else begin
            st_q <= S_POP;
            if (mode_q == ModeReassign && len_q < LenW'(ListDepth)) len_q <= len_q + LenW'(1);
          end
        end
        S_POP: begin
          next_q <= head; len_q <= len_q - LenW'(1); vi_q <= '0; st_q <= S_RE;
        end
        S_OFF, S_RE: begin
          if (note_q[vi_q] == d1_q && (st_q == S_OFF || gate_q[vi_q])) begin
            gate_q[vi_q] <= 1'b0; vel_q[vi_q] <= d2_q; rmp_q <= '0;
            st_q <= (st_q == S_OFF) ? S_OFF_RM : S_RE_RM;
          end else if (32'(vi_q) == Voices-1) begin
            st_q <= (st_q == S_OFF) ? S_FIN : S_MODE2;
          end else vi_q <= vi_q + VoiceW'(1);
        end
        S_OFF_RM, S_RE_RM: begin
          if (found) begin rmp_q <= fpos; len_q <= len_q - LenW'(1); end
          else st_q <= (st_q == S_OFF_RM) ? S_OFF_PF : S_RE_PF;
        end
        S_OFF_PF, S_RE_PF: begin
          if (len_q < LenW'(ListDepth)) len_q <= len_q + LenW'(1);
          if (32'(vi_q) == Voices-1) st_q <= (st_q == S_OFF_PF) ? S_FIN : S_MODE2;
          else begin vi_q <= vi_q + VoiceW'(1); st_q <= (st_q == S_OFF_PF) ? S_OFF : S_RE; end
        end
        S_MODE2: begin
          if (32'(next_q) < Voices) begin
            gate_q[next_q] <= 1'b1; note_q[next_q] <= d1_q; vel_q[next_q] <= d2_q;
          end
          st_q <= S_FIN;
        end
        S_FIN: begin ov_q <= 1'b1; oi_q <= '0; st_q <= S_OUT; end
        S_OUT: if (m_axis_tready) begin
          if (32'(oi_q) == Voices-1) begin
            ov_q <= 1'b0; oi_q <= '0; st_q <= S_IDLE;
          end else oi_q <= oi_q + (VoiceW+1)'(1);
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // cell command per state
  always_comb begin
    cmd.op = OP_HOLD; cmd.value = '0; cmd.pos = len_q;
    case (st_q)
      S_PB: begin cmd.op = OP_WRITE_AT; cmd.value = pb_q; end
      S_SORT: cmd.op = cnt_q[0] ? OP_SORT_ODD : OP_SORT_EVEN;
      S_MODE: if (mode_q == ModeReassign) begin cmd.op = OP_WRITE_AT; cmd.value = head; end
      S_POP: cmd.op = OP_SHIFT_DOWN;
      S_OFF_RM, S_RE_RM: if (found) cmd.op = OP_COMPACT;
      S_OFF_PF, S_RE_PF: begin cmd.op = OP_SET_FRONT; cmd.value = vi_q; end
      default: cmd.op = OP_HOLD;
    endcase
  end

  logic [VoiceW-1:0] ov;
  assign ov = oi_q[VoiceW-1:0];
  assign m_axis_tvalid = ov_q && (st_q == S_OUT);
  assign m_axis_tlast  = 32'(oi_q) == Voices-1;
  assign m_axis_tdata  = {7'b0, pres_q[ov], vel_q[ov], note_q[ov], gate_q[ov], IdxW'(oi_q)};

endmodule

// ===== test/midi_voice_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_voice_allocator_unit_tb: self-checking bench of the voice allocator
// Sends MIDI messages and reset events under several channel filter and mode
// settings, predicts the six voice states after every transaction and checks
// each output transaction against them, with random idling on both sides.
// ----------------------------------------------------------------------------
module midi_voice_allocator_unit_tb
  import mva_pkg::*;
();

  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [2:0] index;
    logic       gate;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [6:0] pressure;
    logic       last;
  } voice_state_t;

  // expected voice states and result checking
  class voice_board;
    voice_state_t pending_q[$];
    int unsigned  errors;
    int unsigned  seen;

    function void note_item(voice_state_t states[Voices]);
      foreach (states[i]) pending_q.insert(pending_q.size(), states[i]);
    endfunction

    function void check_voice(voice_state_t got);
      voice_state_t want;
      seen++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected voice transaction %h", $time, got);
        return;
      end
      want = pending_q[0];
      pending_q.delete(0);
      if (got != want) begin
        errors++;
        $display("%0t: mismatch expected idx=%0d g=%0d n=%0d v=%0d p=%0d l=%0d", $time,
                 want.index, want.gate, want.note, want.velocity, want.pressure, want.last);
        $display("%0t:          actual   idx=%0d g=%0d n=%0d v=%0d p=%0d l=%0d", $time,
                 got.index, got.gate, got.note, got.velocity, got.pressure, got.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [4:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  midi_voice_allocator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  voice_board  board;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_cycles;
  int unsigned items_sent;
  int unsigned resets_sent;

  // predicted allocator state
  logic [6:0] note_mem [Voices];
  logic [6:0] vel_mem [Voices];
  logic [6:0] pres_mem [Voices];
  logic       gate_mem [Voices];
  int unsigned free_list [ListDepth];
  int unsigned free_len;
  logic       pedal_down;
  int         chan_sel;
  logic [1:0] alloc_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void free_append(int unsigned v);
    if (free_len >= ListDepth) return;
    free_list[free_len] = v;
    free_len++;
  endfunction

  function automatic void free_prepend(int unsigned v);
    int unsigned n;
    n = (free_len >= ListDepth) ? ListDepth - 1 : free_len;
    for (int k = n; k > 0; k--) free_list[k] = free_list[k-1];
    free_list[0] = v;
    free_len = n + 1;
  endfunction

  function automatic void free_drop(int unsigned v);
    int unsigned w;
    w = 0;
    for (int r = 0; r < free_len; r++) begin
      if (free_list[r] != v) begin
        free_list[w] = free_list[r];
        w++;
      end
    end
    free_len = w;
  endfunction

  function automatic void free_sort();
    int unsigned x;
    int j;
    for (int i = 1; i < free_len; i++) begin
      x = free_list[i];
      j = i;
      while (j > 0 && free_list[j-1] > x) begin
        free_list[j] = free_list[j-1];
        j--;
      end
      free_list[j] = x;
    end
  endfunction

  function automatic void clear_all_voices();
    for (int i = 0; i < Voices; i++) begin
      gate_mem[i] = 1'b0;
      vel_mem[i]  = '0;
      pres_mem[i] = '0;
    end
    free_len   = 0;
    pedal_down = 1'b0;
  endfunction

  // voice update for one midi message
  function automatic void allocate_voices(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
    logic [3:0]  kind;
    logic        gate_on;
    logic        any_on;
    int unsigned next_voice;
    kind = status[7:4];
    any_on = 1'b0;
    if (chan_sel >= 0 && chan_sel != int'(status[3:0])) return;
    if (kind == KindNoteOff) begin
      gate_on = 1'b0;
    end else if (kind == KindNoteOn) begin
      gate_on = (d2 != 0);
    end else if (kind == KindPolyPres) begin
      for (int i = 0; i < Voices; i++) if (note_mem[i] == d1) pres_mem[i] = d2;
      return;
    end else if (kind == KindCtrl) begin
      if (d1 == CtrlSustain) begin
        pedal_down = (d2 >= 64);
        if (!pedal_down) begin
          free_len = 0;
          for (int i = 0; i < Voices; i++) begin
            gate_mem[i] = 1'b0;
            free_append(i);
          end
        end
      end
      return;
    end else begin
      return;
    end

    // note-off path
    if (!gate_on) begin
      if (pedal_down) return;
      for (int i = 0; i < Voices; i++) begin
        if (note_mem[i] == d1) begin
          gate_mem[i] = 1'b0;
          vel_mem[i]  = d2;
          free_drop(i);
          free_prepend(i);
        end
      end
      return;
    end

    // note-on path
    if (free_len == 0) for (int i = 0; i < Voices; i++) free_append(i);
    for (int i = 0; i < Voices; i++) if (gate_mem[i]) any_on = 1'b1;
    if (!any_on) free_sort();
    if (alloc_mode == ModeReset) begin
      if (free_len == Voices) begin
        for (int i = 0; i < Voices; i++) begin
          gate_mem[i] = 1'b0;
          free_append(i);
        end
      end
    end else if (alloc_mode == ModeReassign) begin
      free_append(free_list[0]);
    end
    next_voice = free_list[0];
    free_len--;
    for (int k = 0; k < free_len; k++) free_list[k] = free_list[k+1];
    for (int i = 0; i < Voices; i++) begin
      if (note_mem[i] == d1 && gate_mem[i]) begin
        vel_mem[i] = d2;
        free_drop(i);
        free_prepend(i);
        gate_mem[i] = 1'b0;
      end
    end
    if (next_voice < Voices) begin
      gate_mem[next_voice] = 1'b1;
      note_mem[next_voice] = d1;
      vel_mem[next_voice]  = d2;
    end
  endfunction

  function automatic void predict_voices(logic func, logic [7:0] status, logic [6:0] d1,
                                         logic [6:0] d2);
    voice_state_t states [Voices];
    if (func) clear_all_voices();
    else allocate_voices(status, d1, d2);
    for (int i = 0; i < Voices; i++) begin
      states[i].index    = 3'(i);
      states[i].gate     = gate_mem[i];
      states[i].note     = note_mem[i];
      states[i].velocity = vel_mem[i];
      states[i].pressure = pres_mem[i];
      states[i].last     = (i == Voices - 1);
    end
    board.note_item(states);
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_msg(logic func, logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = {2'b00, d2, d1, status};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_voices(func, status, d1, d2);
    items_sent++;
    if (func) resets_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  // registers change only while idle; a reset event follows each change
  task automatic write_settings(int filt, logic [1:0] mode);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_index_i = RegChannelFilter;
    cfg_data_i  = filt[4:0];
    @(negedge clk_i);
    cfg_index_i = RegVoiceMode;
    cfg_data_i  = {3'b000, mode};
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    chan_sel   = filt;
    alloc_mode = mode;
    send_msg(1'b1, 8'($urandom), 7'($urandom), 7'($urandom));
  endtask

  task automatic send_random(int unsigned count);
    int unsigned pick;
    logic [3:0]  chan;
    logic [6:0]  key;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      chan = (chan_sel >= 0 && $urandom_range(9) != 0) ? chan_sel[3:0] : 4'($urandom);
      key  = ($urandom_range(4) == 0) ? 7'($urandom) : 7'(60 + $urandom_range(7));
      if (pick < 40) send_msg(1'b0, {KindNoteOn, chan}, key, 7'($urandom_range(127)));
      else if (pick < 65) send_msg(1'b0, {KindNoteOff, chan}, key, 7'($urandom));
      else if (pick < 75) send_msg(1'b0, {KindPolyPres, chan}, key, 7'($urandom));
      else if (pick < 85) send_msg(1'b0, {KindCtrl, chan}, CtrlSustain, 7'($urandom));
      else if (pick < 88) send_msg(1'b1, 8'($urandom), 7'($urandom), 7'($urandom));
      else send_msg(1'b0, 8'($urandom), 7'($urandom), 7'($urandom));
    end
  endtask

  // receive side: random stalls and result checking
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_voice({m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[10:4],
                         m_axis_tdata[17:11], m_axis_tdata[24:18], m_axis_tlast});
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("** midi_voice_allocator_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    board         = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = RegChannelFilter;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 85;
    stall_cycles  = 0;
    items_sent    = 0;
    resets_sent   = 0;
    chan_sel      = -1;
    alloc_mode    = ModeReassign;
    for (int i = 0; i < Voices; i++) note_mem[i] = NoteReset;
    foreach (free_list[i]) free_list[i] = 0;
    clear_all_voices();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every message kind, pedal, retrigger, overflow
    send_msg(1'b0, {KindNoteOn, 4'h0}, 7'd0, 7'd127);
    send_msg(1'b0, {KindNoteOn, 4'hF}, 7'd127, 7'd1);
    send_msg(1'b0, {KindNoteOn, 4'h3}, 7'd127, 7'd90);
    send_msg(1'b0, {KindPolyPres, 4'h1}, 7'd127, 7'd127);
    send_msg(1'b0, {KindNoteOn, 4'h2}, 7'd0, 7'd0);
    send_msg(1'b0, {KindNoteOff, 4'h2}, 7'd127, 7'd64);
    send_msg(1'b0, {KindCtrl, 4'h0}, CtrlSustain, 7'd127);
    send_msg(1'b0, {KindNoteOn, 4'h0}, 7'd61, 7'd50);
    send_msg(1'b0, {KindNoteOff, 4'h0}, 7'd61, 7'd10);
    send_msg(1'b0, {KindCtrl, 4'h0}, 7'd7, 7'd0);
    send_msg(1'b0, {KindCtrl, 4'h0}, CtrlSustain, 7'd63);
    for (int k = 0; k < 8; k++) send_msg(1'b0, {KindNoteOn, 4'h5}, 7'(40 + k), 7'(k + 1));
    send_msg(1'b0, {4'hC, 4'h0}, 7'd5, 7'd5);
    send_msg(1'b0, 8'hFF, 7'd127, 7'd127);
    send_msg(1'b1, 8'hFF, 7'd127, 7'd127);
    send_random(25);

    // pause until everything has drained, then go on
    wait_drained();
    write_settings(15, ModeReset);
    send_random(40);
    write_settings(-16, ModeRotate);
    send_random(20);
    send_idle_pct = 85;
    recv_idle_pct = 23;
    write_settings(0, ModeReassign);
    send_random(40);
    write_settings(7, 2'd3);
    send_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(-1, ModeReset);
    send_random(40);
    write_settings(-1, ModeReassign);
    send_random(30);

    wait_drained();
    $display("covered %0d transactions (%0d reset events), %0d voice states checked,",
             items_sent, resets_sent, board.seen);
    $display("channel filter at both ends and off, all four mode codes, pedal hold/release");
    if (board.errors == 0) begin
      $display("** midi_voice_allocator_unit: PASSED **");
    end else begin
      $display("** midi_voice_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mva_pkg.sv
rtl/mva_list_cell.sv
rtl/midi_voice_allocator_unit.sv
test/midi_voice_allocator_unit_tb.sv
